### rtl/bpm_pkg.sv
// Package: shared constants, register indexes, types and a tag helper for the moat masker.
`timescale 1ns / 1ps
package bpm_pkg;

    localparam int PIX_BITS       = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int DIM_W          = 13;
    localparam int MOAT_REG_W     = 4;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_MOAT   = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OVERLOAD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PUNCH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOAT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd6;

    // command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef logic [PIX_BITS-1:0] t_pix;

    // one delayed pixel: target plus its two flags
    typedef struct packed {
        logic bad;
        logic moat_match;
        t_pix target;
    } t_entry;

    // largest pixel value that is none of the three tags
    function automatic t_pix derive_moat_tag(t_pix ovl, t_pix ign, t_pix pun);
        t_pix t;
        t = '1;
        for (int i = 0; i < 4; i++) begin
            if (t == ovl || t == ign || t == pun) begin
                t = t - t_pix'(1);
            end
        end
        return t;
    endfunction

endpackage

### rtl/bpm_if.sv
// Interfaces: pixel input channel, result output channel and register write channel.
`timescale 1ns / 1ps
interface bpm_in_if;
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [bpm_pkg::PIX_BITS-1:0] target_value;
    logic [bpm_pkg::PIX_BITS-1:0] reference_value;
    logic [bpm_pkg::PIX_BITS-1:0] mask_value;
    modport source (output valid, command, target_value, reference_value, mask_value,
                    input ready);
    modport sink   (input valid, command, target_value, reference_value, mask_value,
                    output ready);
endinterface

interface bpm_out_if;
    logic                    valid;
    logic                    ready;
    logic [bpm_pkg::PIX_BITS-1:0] out_value;
    logic                    frame_last;
    modport source (output valid, out_value, frame_last, input ready);
    modport sink   (input valid, out_value, frame_last, output ready);
endinterface

interface bpm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bpm_pkg::CFG_IDX_W-1:0]  index;
    logic [bpm_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/bragg_peak_moat_masker.sv
// Top level: threshold, square dilation and tag replacement over a pixel triple stream.
// Delay: a pixel is emitted moat*width+moat items after it entered, and then passes
// through the memory read stage and the output register.
// Throughput: one item per cycle unless the output stalls or a write settles, set by
// the read-modify-write of the column age memory and the delay store (forwarding
// covers a one-column image). Reset and every write to a defined register restart the
// frame; items are held off after it while derived sizes settle. No clearing pass.
`timescale 1ns / 1ps
module bragg_peak_moat_masker #(
    parameter int MAX_WIDTH = bpm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_MOAT  = bpm_pkg::DEF_MAX_MOAT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpm_in_if.sink     i_in,
    bpm_out_if.source  o_out,
    bpm_cfg_if.sink    i_cfg
);
    import bpm_pkg::*;

    localparam int WL      = 2 * MAX_MOAT + 1;
    localparam int AGE_SAT = 2 * MAX_MOAT + 1;
    localparam int AW      = $clog2(AGE_SAT + 1);
    localparam int DEPTH   = MAX_MOAT * MAX_WIDTH + MAX_MOAT + 1;
    localparam int SW      = $clog2(DEPTH);
    localparam int CLW     = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int MW      = $clog2(MAX_MOAT + 1);
    localparam int CW      = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);

    // configuration registers
    t_pix                  r_ovl, r_ign, r_pun, r_thr;
    logic [MOAT_REG_W-1:0] r_moat;
    logic [DIM_W-1:0]      r_wid, r_hgt;
    logic                  r_settle;

    // derived values, registered
    logic [WW-1:0] r_w_eff;
    logic [MW-1:0] r_m_eff;
    logic [CW-1:0] r_total, r_delay;
    t_pix          r_mtag;

    // position state
    logic [CW-1:0]  r_pos, r_emit_cnt;
    logic [CLW-1:0] r_col;
    logic           r_row0;
    logic [SW-1:0]  r_wr_ptr, r_rd_ptr;

    // memories
    logic [AW-1:0] age_mem [MAX_WIDTH];
    t_entry        store_mem [DEPTH];
    logic [AW-1:0] r_age_rd;
    t_entry        r_st_rd;

    // memory stage
    logic           r_s1_valid, r_s1_emit, r_s1_seed, r_s1_row0, r_s1_fwd;
    logic           r_s1_clr, r_s1_byp, r_s1_last;
    logic [CLW-1:0] r_s1_col;
    t_entry         r_s1_entry;
    logic [AW-1:0]  r_fwd_age;
    logic [WL-1:0]  r_win;
    logic [CLW-1:0] r_out_col;

    // output register
    logic r_out_valid;
    t_pix r_out_value;
    logic r_out_last;

    // ---------------- handshakes
    logic s1_fire, in_acc, cfg_acc;
    assign s1_fire     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_settle && (!r_s1_valid || s1_fire);
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid;

    // ---------------- derived sizes
    logic [WW-1:0] w_eff_c;
    logic [13:0]   h_eff_c;
    logic [MW-1:0] m_eff_c;
    always_comb begin
        if (r_wid == '0) w_eff_c = WW'(1);
        else if (32'(r_wid) > 32'(MAX_WIDTH)) w_eff_c = WW'(MAX_WIDTH);
        else w_eff_c = WW'(r_wid);
        if (r_hgt == '0) h_eff_c = 14'd1;
        else if (32'(r_hgt) > 32'(HEIGHT_LIMIT)) h_eff_c = 14'(HEIGHT_LIMIT);
        else h_eff_c = 14'(r_hgt);
        if (32'(r_moat) > 32'(MAX_MOAT)) m_eff_c = MW'(MAX_MOAT);
        else m_eff_c = MW'(r_moat);
    end

    always_ff @(posedge i_clk) begin
        r_w_eff <= w_eff_c;
        r_m_eff <= m_eff_c;
        r_total <= CW'(w_eff_c) * CW'(h_eff_c);
        r_delay <= CW'(m_eff_c) * CW'(w_eff_c) + CW'(m_eff_c);
        r_mtag  <= derive_moat_tag(r_ovl, r_ign, r_pun);
    end

    // ---------------- input item decode
    logic           is_pix, new_frame, adv, emit, seed, k_tagged;
    logic [CW-1:0]  pos_b, emit_b;
    logic [CLW-1:0] col_b;
    logic           row0_b;
    logic [SW-1:0]  wr_b, rd_b;
    t_entry         entry_c;
    t_pix           tv, rv, kv;
    always_comb begin
        tv        = i_in.target_value;
        rv        = i_in.reference_value;
        kv        = i_in.mask_value;
        is_pix    = (i_in.command == CMD_PIXEL);
        new_frame = is_pix && (r_emit_cnt >= r_total);
        pos_b     = new_frame ? '0 : r_pos;
        emit_b    = new_frame ? '0 : r_emit_cnt;
        col_b     = new_frame ? '0 : r_col;
        row0_b    = new_frame ? 1'b1 : r_row0;
        wr_b      = new_frame ? '0 : r_wr_ptr;
        rd_b      = new_frame ? '0 : r_rd_ptr;
        if (is_pix) adv = (pos_b < r_total);
        else adv = (r_pos >= r_total) && (r_emit_cnt < r_total);
        emit      = adv && (pos_b >= r_delay);
        k_tagged  = (kv == r_ovl) || (kv == r_ign) || (kv == r_pun);
        seed      = is_pix && ((kv == r_pun) || (!k_tagged && kv > r_thr));
        entry_c.target     = tv;
        entry_c.bad        = (rv == r_ovl) || (rv == r_ign) || (kv == r_ovl) || (kv == r_ign);
        entry_c.moat_match = (kv == r_mtag);
    end

    // ---------------- memory stage logic
    logic [AW-1:0]  age_in, age_new;
    logic [WL-1:0]  win_b, win_new;
    logic [CLW-1:0] oc_b;
    logic           dilated;
    t_entry         ent;
    t_pix           v;
    int             cidx;
    always_comb begin
        if (r_s1_row0) age_in = AW'(AGE_SAT);
        else if (r_s1_fwd) age_in = r_fwd_age;
        else age_in = r_age_rd;
        if (r_s1_seed) age_new = '0;
        else if (age_in < AW'(AGE_SAT)) age_new = age_in + AW'(1);
        else age_new = age_in;
        win_b   = r_s1_clr ? '0 : r_win;
        win_new = {win_b[WL-2:0], (32'(age_new) <= 32'(2 * r_m_eff))};
        oc_b    = r_s1_clr ? '0 : r_out_col;
        dilated = 1'b0;
        for (int k = 0; k < WL; k++) begin
            cidx = int'(oc_b) + int'(r_m_eff) - k;
            if (k <= 2 * int'(r_m_eff) && cidx >= 0 && cidx < int'(r_w_eff) && win_new[k])
                dilated = 1'b1;
        end
        ent = r_s1_byp ? r_s1_entry : r_st_rd;
        v   = ent.target;
        if (v != r_ovl && v != r_ign && v != r_pun) begin
            if (ent.bad) v = r_ign;
            else if (dilated || ent.moat_match) v = r_pun;
        end
    end

    // ---------------- memories
    always_ff @(posedge i_clk) begin
        if (in_acc && adv) begin
            r_age_rd <= age_mem[col_b];
            r_st_rd  <= store_mem[rd_b];
        end
        if (in_acc && adv && is_pix) store_mem[wr_b] <= entry_c;
        if (s1_fire) age_mem[r_s1_col] <= age_new;
    end

    // ---------------- configuration and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovl      <= 16'hFFFF;
            r_ign      <= 16'hFFFE;
            r_pun      <= 16'hFFFD;
            r_thr      <= 16'hFFFF;
            r_moat     <= MOAT_REG_W'(1);
            r_wid      <= DIM_W'(1024);
            r_hgt      <= DIM_W'(1024);
            r_settle   <= 1'b1;
            r_pos      <= '0;
            r_emit_cnt <= '0;
            r_col      <= '0;
            r_row0     <= 1'b1;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
        end else begin
            r_settle <= 1'b0;
            if (cfg_acc && i_cfg.index <= REG_HEIGHT) begin
                unique case (i_cfg.index)
                    REG_OVERLOAD:  r_ovl  <= i_cfg.data;
                    REG_IGNORE:    r_ign  <= i_cfg.data;
                    REG_PUNCH:     r_pun  <= i_cfg.data;
                    REG_THRESHOLD: r_thr  <= i_cfg.data;
                    REG_MOAT:      r_moat <= i_cfg.data[MOAT_REG_W-1:0];
                    REG_WIDTH:     r_wid  <= i_cfg.data[DIM_W-1:0];
                    REG_HEIGHT:    r_hgt  <= i_cfg.data[DIM_W-1:0];
                    default:       r_thr  <= r_thr;
                endcase
                r_settle   <= 1'b1;
                r_pos      <= '0;
                r_emit_cnt <= '0;
                r_col      <= '0;
                r_row0     <= 1'b1;
                r_wr_ptr   <= '0;
                r_rd_ptr   <= '0;
            end else if (in_acc && adv) begin
                r_pos <= pos_b + CW'(1);
                if (32'(col_b) + 1 >= 32'(r_w_eff)) begin
                    r_col  <= '0;
                    r_row0 <= 1'b0;
                end else begin
                    r_col  <= col_b + CLW'(1);
                    r_row0 <= row0_b;
                end
                r_wr_ptr <= (32'(wr_b) == DEPTH - 1) ? '0 : wr_b + SW'(1);
                if (emit) begin
                    r_emit_cnt <= emit_b + CW'(1);
                    r_rd_ptr   <= (32'(rd_b) == DEPTH - 1) ? '0 : rd_b + SW'(1);
                end else begin
                    r_emit_cnt <= emit_b;
                    r_rd_ptr   <= rd_b;
                end
            end
        end
    end

    // ---------------- memory stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_win      <= '0;
            r_out_col  <= '0;
        end else begin
            if (cfg_acc && i_cfg.index <= REG_HEIGHT) begin
                r_win     <= '0;
                r_out_col <= '0;
            end else if (s1_fire) begin
                r_win <= win_new;
                if (r_s1_emit)
                    r_out_col <= (32'(oc_b) + 1 >= 32'(r_w_eff)) ? '0 : oc_b + CLW'(1);
                else
                    r_out_col <= oc_b;
            end
            if (in_acc && adv) r_s1_valid <= 1'b1;
            else if (s1_fire) r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && adv) begin
            r_s1_emit  <= emit;
            r_s1_seed  <= seed;
            r_s1_row0  <= row0_b;
            r_s1_col   <= col_b;
            r_s1_fwd   <= s1_fire && (r_s1_col == col_b);
            r_fwd_age  <= age_new;
            r_s1_clr   <= new_frame;
            r_s1_byp   <= (r_delay == '0);
            r_s1_entry <= entry_c;
            r_s1_last  <= (emit_b == r_total - CW'(1));
        end
    end

    // ---------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_emit) begin
            r_out_value <= v;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_value  = r_out_value;
    assign o_out.frame_last = r_out_last;

endmodule

### bench/bragg_peak_moat_masker_test.sv
// Testbench: directed table and random frames through the moat masker, checked by a predictor.
`timescale 1ns / 1ps
module bragg_peak_moat_masker_test;
    import bpm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int STORE_DEPTH = DEF_MAX_MOAT * DEF_MAX_WIDTH + DEF_MAX_MOAT + 1;
    localparam int AGE_SAT     = 2 * DEF_MAX_MOAT + 1;
    localparam int IDLE_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 950;

    typedef struct {
        t_pix value;
        logic last;
    } t_result;

    typedef struct {
        logic cmd;
        t_pix tgt;
        t_pix ref_pix;
        t_pix msk;
        bit   typed;
        t_pix exp_value;
        logic exp_last;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bpm_in_if  in_ch ();
    bpm_out_if out_ch ();
    bpm_cfg_if cfg_ch ();

    bragg_peak_moat_masker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_pix         ovl_tag, ign_tag, pun_tag, thr, derived_tag;
    logic [3:0]   moat_reg;
    logic [12:0]  width_reg, height_reg;
    logic [4:0]   col_age [DEF_MAX_WIDTH];
    t_entry       delay_mem [STORE_DEPTH];
    logic [2*DEF_MAX_MOAT:0] flag_win;
    int unsigned  in_col, pos, out_col, emitted;
    bit           item_took;

    t_result pending_q[$];
    int      fail_count = 0;
    int      idle_cycles = 0;
    int      gap_pct = 0;
    int      stall_pct = 0;
    int      took_count = 0;

    function automatic int unsigned cur_w();
        if (width_reg == 0) return 1;
        return (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
    endfunction

    function automatic int unsigned cur_h();
        if (height_reg == 0) return 1;
        return (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
    endfunction

    function automatic int unsigned cur_m();
        return (moat_reg > DEF_MAX_MOAT) ? DEF_MAX_MOAT : moat_reg;
    endfunction

    function automatic void restart_frame();
        for (int i = 0; i < DEF_MAX_WIDTH; i++) col_age[i] = 5'(AGE_SAT);
        flag_win = '0;
        in_col = 0;
        pos = 0;
        out_col = 0;
        emitted = 0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_pix t;
        case (idx)
            REG_OVERLOAD:  ovl_tag = data;
            REG_IGNORE:    ign_tag = data;
            REG_PUNCH:     pun_tag = data;
            REG_THRESHOLD: thr = data;
            REG_MOAT:      moat_reg = data[3:0];
            REG_WIDTH:     width_reg = data[12:0];
            REG_HEIGHT:    height_reg = data[12:0];
            default:       return;
        endcase
        t = '1;
        while (t == ovl_tag || t == ign_tag || t == pun_tag) t = t - 1'b1;
        derived_tag = t;
        restart_frame();
    endfunction

    // one real or drain position through the dilation; returns 1 when a pixel is due
    function automatic bit shift_position(bit seed, output t_result res);
        int unsigned w, m, total, delay, j;
        logic [4:0] age;
        bit dil;
        int colx;
        t_entry e;
        t_pix v;
        w = cur_w();
        m = cur_m();
        total = w * cur_h();
        delay = m * w + m;
        age = col_age[in_col];
        if (seed) age = '0;
        else if (age < AGE_SAT) age = age + 1'b1;
        col_age[in_col] = age;
        flag_win = {flag_win[2*DEF_MAX_MOAT-1:0], (age <= 2 * m)};
        pos++;
        in_col++;
        if (in_col >= w) in_col = 0;
        if (pos <= delay) return 0;
        j = pos - 1 - delay;
        dil = 0;
        for (int k = 0; k <= 2 * m; k++) begin
            colx = int'(out_col) + int'(m) - k;
            if (colx >= 0 && colx < int'(w) && flag_win[k]) dil = 1;
        end
        e = delay_mem[j % STORE_DEPTH];
        v = e.target;
        if (v != ovl_tag && v != ign_tag && v != pun_tag) begin
            if (e.bad) v = ign_tag;
            else if (dil || e.moat_match) v = pun_tag;
        end
        res.value = v;
        res.last = (j == total - 1);
        out_col++;
        if (out_col >= w) out_col = 0;
        emitted++;
        return 1;
    endfunction

    function automatic bit predict_item(logic cmd, t_pix t, t_pix r, t_pix k,
                                        output t_result res);
        int unsigned total;
        bit mask_is_tag, seed;
        t_entry e;
        total = cur_w() * cur_h();
        item_took = 0;
        res.value = '0;
        res.last = 1'b0;
        if (cmd == CMD_PIXEL) begin
            if (emitted >= total) restart_frame();
            if (pos >= total) return 0;
            mask_is_tag = (k == ovl_tag || k == ign_tag || k == pun_tag);
            seed = (k == pun_tag) || (!mask_is_tag && k > thr);
            e.target = t;
            e.bad = (r == ovl_tag || r == ign_tag || k == ovl_tag || k == ign_tag);
            e.moat_match = (k == derived_tag);
            delay_mem[pos % STORE_DEPTH] = e;
            item_took = 1;
            return shift_position(seed, res);
        end
        if (pos < total || emitted >= total) return 0;
        item_took = 1;
        return shift_position(0, res);
    endfunction

    // result checking and idle watchdog
    always @(posedge i_clk) begin
        t_result exp_r;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("bragg_peak_moat_masker test failed");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_q.size() == 0) begin
                $error("result with no expectation: out_value %0d", out_ch.out_value);
                fail_count++;
            end else begin
                exp_r = pending_q.pop_front();
                if (out_ch.out_value !== exp_r.value) begin
                    $error("out_value expected %0d actual %0d", exp_r.value, out_ch.out_value);
                    fail_count++;
                end
                if (out_ch.frame_last !== exp_r.last) begin
                    $error("frame_last expected %0d actual %0d", exp_r.last,
                           out_ch.frame_last);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_item(logic cmd, t_pix t, t_pix r, t_pix k,
                             bit typed = 0, t_pix tv = '0, logic tl = 1'b0);
        t_result res;
        bit has;
        while ($urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.target_value <= t;
        in_ch.reference_value <= r;
        in_ch.mask_value <= k;
        do @(posedge i_clk); while (!in_ch.ready);
        has = predict_item(cmd, t, r, k, res);
        if (item_took) took_count++;
        if (typed) begin
            res.value = tv;
            res.last = tl;
        end
        if (has) pending_q.push_back(res);
    endtask

    // hold input until every expected result has come
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain_results();
        repeat (8) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    function automatic t_pix pick_pixel();
        case ($urandom_range(11))
            0: return ovl_tag;
            1: return ign_tag;
            2: return pun_tag;
            3: return derived_tag;
            4: return thr;
            5: return thr + 1'b1;
            6: return '0;
            7: return '1;
            default: return t_pix'($urandom_range(65535));
        endcase
    endfunction

    function automatic t_pix pick_target();
        if ($urandom_range(5) == 0) return pick_pixel();
        return t_pix'($urandom_range(65535));
    endfunction

    function automatic t_pix pick_ref();
        if ($urandom_range(9) == 0) return pick_pixel();
        return t_pix'($urandom_range(65535));
    endfunction

    // one frame of well-formed pixels, some noise, then the drain
    task automatic run_frame(bit pause_mid);
        int unsigned total;
        total = cur_w() * cur_h();
        for (int unsigned i = 0; i < total; i++) begin
            if ($urandom_range(39) == 0)
                send_item(CMD_DRAIN, pick_target(), pick_ref(), pick_pixel());
            send_item(CMD_PIXEL, pick_target(), pick_ref(), pick_pixel());
            if (pause_mid && i == total / 2) drain_results();
        end
        if (emitted < total && $urandom_range(3) == 0)
            send_item(CMD_PIXEL, pick_target(), pick_ref(), pick_pixel());
        while (emitted < total)
            send_item(CMD_DRAIN, t_pix'($urandom_range(65535)), pick_ref(), pick_pixel());
        if ($urandom_range(3) == 0)
            send_item(CMD_DRAIN, '0, '0, '0);
    endtask

    // the start of a large frame, left for the next register write to cut short
    task automatic run_partial(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_item(CMD_PIXEL, pick_target(), pick_ref(), pick_pixel());
    endtask

    t_row rows [$];

    function automatic void add_row(logic cmd, t_pix t, t_pix r, t_pix k,
                                    bit typed = 0, t_pix tv = '0, logic tl = 1'b0);
        t_row x;
        x.cmd = cmd; x.tgt = t; x.ref_pix = r; x.msk = k;
        x.typed = typed; x.exp_value = tv; x.exp_last = tl;
        rows.push_back(x);
    endfunction

    initial begin
        int phase;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_PIXEL;
        in_ch.target_value = '0;
        in_ch.reference_value = '0;
        in_ch.mask_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_OVERLOAD;
        cfg_ch.data = '0;
        ovl_tag = 16'd65535; ign_tag = 16'd65534; pun_tag = 16'd65533;
        thr = 16'd65535; moat_reg = 4'd1; width_reg = 13'd1024; height_reg = 13'd1024;
        derived_tag = 16'd65532;
        restart_frame();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 4x2 frame, no moat, threshold 100
        write_reg(REG_MOAT, 16'd0);
        write_reg(REG_WIDTH, 16'd4);
        write_reg(REG_HEIGHT, 16'd2);
        write_reg(REG_THRESHOLD, 16'd100);
        add_row(CMD_PIXEL, 16'd0, 16'd0, 16'd0, 1, 16'd0, 1'b0);
        add_row(CMD_PIXEL, 16'd65535, 16'd65534, 16'd65533, 1, 16'd65535, 1'b0);
        add_row(CMD_PIXEL, 16'd65534, 16'd0, 16'd0, 1, 16'd65534, 1'b0);
        add_row(CMD_PIXEL, 16'd65533, 16'd0, 16'd0, 1, 16'd65533, 1'b0);
        add_row(CMD_PIXEL, 16'd5, 16'd65535, 16'd0, 1, 16'd65534, 1'b0);
        add_row(CMD_PIXEL, 16'd5, 16'd0, 16'd65534, 1, 16'd65534, 1'b0);
        add_row(CMD_PIXEL, 16'd5, 16'd0, 16'd101, 1, 16'd65533, 1'b0);
        add_row(CMD_PIXEL, 16'd7, 16'd0, 16'd65532, 1, 16'd65533, 1'b1);
        add_row(CMD_DRAIN, 16'd0, 16'd0, 16'd0);
        add_row(CMD_PIXEL, 16'd9, 16'd0, 16'd100, 1, 16'd9, 1'b0);
        add_row(CMD_PIXEL, 16'd1, 16'd0, 16'd65533, 1, 16'd65533, 1'b0);
        add_row(CMD_DRAIN, 16'd0, 16'd0, 16'd0);
        add_row(CMD_PIXEL, 16'd65535, 16'd65535, 16'd65535, 1, 16'd65535, 1'b0);
        add_row(CMD_PIXEL, 16'd12345, 16'd0, 16'd65535, 1, 16'd65534, 1'b0);
        add_row(CMD_PIXEL, 16'hAAAA, 16'h5555, 16'd100);
        add_row(CMD_PIXEL, 16'h5555, 16'hAAAA, 16'd99);
        add_row(CMD_PIXEL, 16'd42, 16'd42, 16'd101);
        add_row(CMD_PIXEL, 16'd43, 16'd0, 16'd0, 1, 16'd43, 1'b1);
        add_row(CMD_PIXEL, 16'd100, 16'd0, 16'd0);
        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].tgt, rows[i].ref_pix, rows[i].msk,
                      rows[i].typed, rows[i].exp_value, rows[i].exp_last);

        // remaining registers and the unused index
        write_reg(REG_OVERLOAD, 16'd65535);
        write_reg(REG_IGNORE, 16'd65534);
        write_reg(REG_PUNCH, 16'd65533);
        write_reg(REG_UNUSED, 16'hFFFF);

        // random phases, each under its own setting and idling pattern
        phase = 0;
        took_count = 0;
        while (took_count < RANDOM_ITEMS) begin
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 47; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 47; end
                default: begin gap_pct = 12; stall_pct = 12; end
            endcase
            if (phase == 3) begin
                // widest row, one row high, no moat
                write_reg(REG_WIDTH, 16'hFFFF);
                write_reg(REG_HEIGHT, 16'd1);
                write_reg(REG_MOAT, 16'd0);
                run_partial(200);
            end else if (phase == 6) begin
                // tallest column, widest moat
                write_reg(REG_WIDTH, 16'd0);
                write_reg(REG_HEIGHT, 16'd8191);
                write_reg(REG_MOAT, 16'd15);
                run_partial(150);
            end else begin
                if ($urandom_range(2) == 0) begin
                    write_reg(REG_OVERLOAD, 16'($urandom_range(65535)));
                    write_reg(REG_IGNORE, 16'($urandom_range(65535)));
                    write_reg(REG_PUNCH, 16'($urandom_range(65535)));
                end else if ($urandom_range(1) == 0) begin
                    write_reg(REG_OVERLOAD, 16'd65535);
                    write_reg(REG_IGNORE, 16'd65534);
                    write_reg(REG_PUNCH, 16'd65533);
                end
                case ($urandom_range(3))
                    0: write_reg(REG_THRESHOLD, 16'd0);
                    1: write_reg(REG_THRESHOLD, 16'd65535);
                    default: write_reg(REG_THRESHOLD, 16'($urandom_range(40000, 65535)));
                endcase
                write_reg(REG_MOAT, 16'($urandom_range(15)));
                write_reg(REG_WIDTH, 16'($urandom_range(1, 20)) | (16'($urandom_range(7)) << 13));
                write_reg(REG_HEIGHT, 16'($urandom_range(1, 8)));
                // one frame pauses midway and is followed by a threshold write
                if (phase == 1) begin
                    run_frame(1);
                    write_reg(REG_THRESHOLD, 16'($urandom_range(65535)));
                end else begin
                    repeat ($urandom_range(1, 3)) run_frame(phase == 2);
                end
            end
            phase++;
        end

        // wait out the tail
        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) $display("bragg_peak_moat_masker test passed");
        else $display("bragg_peak_moat_masker test failed");
        $finish;
    end

endmodule
